// ===== hw/rtl/rrcd_pkg.sv =====
package rrcd_pkg;

    // parameter defaults
    localparam int DEF_MAX_ROW_WIDTH = 4096;
    localparam int DEF_MAX_ROWS      = 4096;
    localparam int DEF_PIXEL_BITS    = 16;
    localparam int DEF_FRACTION_BITS = 8;

    // configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // configuration register widths
    localparam int THRESH_BITS = 16;
    localparam int OFFSET_BITS = 16;
    localparam int LIMIT_BITS  = 8;
    localparam int MINW_BITS   = 13;
    localparam int ROWW_BITS   = 13;

    // configuration reset values
    localparam logic [THRESH_BITS-1:0] RST_THRESHOLD = '0;
    localparam logic [OFFSET_BITS-1:0] RST_OFFSET    = '0;
    localparam logic [LIMIT_BITS-1:0]  RST_BAD_LIMIT = LIMIT_BITS'(2);
    localparam logic [MINW_BITS-1:0]   RST_MIN_WIDTH = MINW_BITS'(3);
    localparam logic [ROWW_BITS-1:0]   RST_ROW_WIDTH = ROWW_BITS'(4096);

    // saturating tolerance counter
    localparam int                    BELOW_BITS = 8;
    localparam logic [BELOW_BITS-1:0] BELOW_MAX  = 8'd255;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_OFFSET     = 3'd1,
        CFG_BAD_LIMIT  = 3'd2,
        CFG_MIN_WIDTH  = 3'd3,
        CFG_ROW_WIDTH  = 3'd4
    } t_cfg_idx;

endpackage

// ===== hw/rtl/rrcd_ram.sv =====
module rrcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rrcd_div.sv =====
module rrcd_div #(
    parameter int NUM_BITS = 28,
    parameter int Q_BITS   = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_rem_init,
    input  logic [Q_BITS-1:0]   i_low,
    input  logic [NUM_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [Q_BITS-1:0]   o_quot
);

    localparam int CNT_BITS = $clog2(Q_BITS + 1);

    logic [NUM_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_div;
    logic [Q_BITS-1:0]   r_low;
    logic [Q_BITS-1:0]   r_quot;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [NUM_BITS:0]   trial;
    logic [NUM_BITS:0]   diff;
    logic                qbit;

    // one restoring step per cycle, msb first
    always_comb begin
        trial = {r_rem, r_low[Q_BITS-1]};
        diff  = trial - {1'b0, r_div};
        qbit  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(Q_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_div <= i_divisor;
            r_low <= i_low;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= qbit ? diff[NUM_BITS-1:0] : trial[NUM_BITS-1:0];
            r_low  <= r_low << 1;
            r_quot <= {r_quot[Q_BITS-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/row_run_centroid_detect_core.sv =====
// record path: a pixel request is taken while the sequencer is in S_PIX; a closing run that
//   yields a record passes S_DIV, S_RD and S_OUT in that order before the record is shown
// throughput: one pixel per cycle while no record is being built; the shift-subtract
//   divider and the row store read hold off pixel requests until the record is registered
// reset: synchronous active low; clears counters, run state and config to defaults,
//   the row store is not cleared and is only read at columns written in the same row
module row_run_centroid_detect_core #(
    parameter int MAX_ROW_WIDTH = rrcd_pkg::DEF_MAX_ROW_WIDTH,
    parameter int MAX_ROWS      = rrcd_pkg::DEF_MAX_ROWS,
    parameter int PIXEL_BITS    = rrcd_pkg::DEF_PIXEL_BITS,
    parameter int FRACTION_BITS = rrcd_pkg::DEF_FRACTION_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // configuration writes
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [rrcd_pkg::CFG_ADDR_BITS-1:0]          i_cfg_index,
    input  logic [rrcd_pkg::CFG_DATA_BITS-1:0]          i_cfg_data,
    // pixel requests
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic [PIXEL_BITS-1:0]                       i_pixel_value,
    input  logic                                        i_frame_start,
    // edge records
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [$clog2(MAX_ROW_WIDTH)+FRACTION_BITS-1:0] o_centroid_x,
    output logic [$clog2(MAX_ROWS)-1:0]                 o_row_index,
    output logic [PIXEL_BITS-1:0]                       o_peak_value,
    output logic [$clog2(MAX_ROW_WIDTH):0]              o_run_width,
    output logic [PIXEL_BITS+$clog2(MAX_ROW_WIDTH)-1:0] o_run_flux
);

    import rrcd_pkg::*;

    localparam int COL_BITS  = $clog2(MAX_ROW_WIDTH);
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int RUN_BITS  = COL_BITS + 1;
    localparam int FLUX_BITS = PIXEL_BITS + COL_BITS;
    localparam int WSUM_BITS = FLUX_BITS + COL_BITS;
    localparam int CX_BITS   = COL_BITS + FRACTION_BITS;
    // common widths for comparisons between config and datapath values
    localparam int VAL_CMP   = (PIXEL_BITS > THRESH_BITS) ? PIXEL_BITS : THRESH_BITS;
    localparam int LEN_CMP   = (RUN_BITS > MINW_BITS) ? RUN_BITS : MINW_BITS;
    localparam logic [CX_BITS:0] HALF = (CX_BITS+1)'((1 << FRACTION_BITS) >> 1);

    typedef enum logic [1:0] {
        S_PIX,
        S_DIV,
        S_RD,
        S_OUT
    } t_state;

    // configuration registers
    logic [THRESH_BITS-1:0] r_threshold;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [LIMIT_BITS-1:0]  r_bad_limit;
    logic [MINW_BITS-1:0]   r_min_width;
    logic [ROWW_BITS-1:0]   r_row_width;

    // position and run state
    logic [COL_BITS-1:0]   r_col,   n_col;
    logic [ROW_BITS-1:0]   r_row,   n_row;
    logic [FLUX_BITS-1:0]  r_flux,  n_flux;
    logic [WSUM_BITS-1:0]  r_wsum,  n_wsum;
    logic [RUN_BITS-1:0]   r_len,   n_len;
    logic [BELOW_BITS-1:0] r_below, n_below;

    // record being built
    logic [FLUX_BITS-1:0]  r_rec_flux;
    logic [RUN_BITS-1:0]   r_rec_len;
    logic [ROW_BITS-1:0]   r_rec_row;
    logic [CX_BITS-1:0]    r_cx;
    logic [COL_BITS-1:0]   r_peak_col;

    t_state r_state;

    logic                  pix_acc;
    logic                  emit;
    logic [COL_BITS-1:0]   col_cur;
    logic [ROW_BITS-1:0]   row_cur;
    logic [FLUX_BITS-1:0]  flux_cur;
    logic [WSUM_BITS-1:0]  wsum_cur;
    logic [RUN_BITS-1:0]   len_cur;
    logic [BELOW_BITS-1:0] below_cur;
    logic [VAL_CMP-1:0]    pix_ext;
    logic [VAL_CMP-1:0]    off_ext;
    logic [VAL_CMP-1:0]    diff_ext;
    logic [PIXEL_BITS-1:0] v;
    logic                  hit;
    logic                  in_run;
    logic [LEN_CMP-1:0]    eff_width;
    logic [LEN_CMP-1:0]    next_col_ext;
    logic [WSUM_BITS-1:0]  prod;

    logic                  div_start;
    logic                  div_done;
    logic [CX_BITS-1:0]    div_quot;
    logic [CX_BITS:0]      round_sum;
    logic [PIXEL_BITS-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_PIX);
    assign pix_acc     = i_valid && o_ready;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_offset    <= RST_OFFSET;
            r_bad_limit <= RST_BAD_LIMIT;
            r_min_width <= RST_MIN_WIDTH;
            r_row_width <= RST_ROW_WIDTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THRESH_BITS-1:0];
                CFG_OFFSET:    r_offset    <= i_cfg_data[OFFSET_BITS-1:0];
                CFG_BAD_LIMIT: r_bad_limit <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_MIN_WIDTH: r_min_width <= i_cfg_data[MINW_BITS-1:0];
                CFG_ROW_WIDTH: r_row_width <= i_cfg_data[ROWW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pixel datapath: black offset, run tracking, row wrap
    always_comb begin
        // frame start restarts position and run before this pixel counts
        col_cur   = i_frame_start ? '0 : r_col;
        row_cur   = i_frame_start ? '0 : r_row;
        flux_cur  = i_frame_start ? '0 : r_flux;
        wsum_cur  = i_frame_start ? '0 : r_wsum;
        len_cur   = i_frame_start ? '0 : r_len;
        below_cur = i_frame_start ? '0 : r_below;

        // offset subtract, floor at zero
        pix_ext  = VAL_CMP'(i_pixel_value);
        off_ext  = VAL_CMP'(r_offset);
        diff_ext = pix_ext - off_ext;
        v        = (pix_ext >= off_ext) ? diff_ext[PIXEL_BITS-1:0] : '0;

        hit    = (VAL_CMP'(v) >= VAL_CMP'(r_threshold));
        in_run = hit || ((len_cur != '0) &&
                 (BELOW_BITS'(below_cur) <= BELOW_BITS'(r_bad_limit)));
        prod   = WSUM_BITS'(col_cur) * WSUM_BITS'(v);

        n_col   = col_cur;
        n_row   = row_cur;
        n_flux  = flux_cur;
        n_wsum  = wsum_cur;
        n_len   = len_cur;
        n_below = below_cur;
        emit    = 1'b0;

        if (in_run) begin
            if (!hit) begin
                if (below_cur != BELOW_MAX) begin
                    n_below = below_cur + 1'b1;
                end
            end else begin
                n_below = '0;
            end
            n_wsum = wsum_cur + prod;
            n_flux = flux_cur + FLUX_BITS'(v);
            n_len  = len_cur + 1'b1;
        end else if (len_cur != '0) begin
            // run closes here
            emit    = (LEN_CMP'(len_cur) >= LEN_CMP'(r_min_width)) && (flux_cur != '0);
            n_flux  = '0;
            n_wsum  = '0;
            n_len   = '0;
            n_below = '0;
        end

        // zero or oversize row width means the full store
        if ((r_row_width == '0) ||
            (LEN_CMP'(r_row_width) > LEN_CMP'(MAX_ROW_WIDTH))) begin
            eff_width = LEN_CMP'(MAX_ROW_WIDTH);
        end else begin
            eff_width = LEN_CMP'(r_row_width);
        end
        next_col_ext = LEN_CMP'(col_cur) + 1'b1;

        if (next_col_ext >= eff_width) begin
            n_col = '0;
            if (ROW_BITS'(row_cur + 1'b1) == '0 ||
                ({1'b0, row_cur} + 1'b1 >= (ROW_BITS+1)'(MAX_ROWS))) begin
                n_row = '0;
            end else begin
                n_row = row_cur + 1'b1;
            end
            // open run at row end is dropped
            n_flux  = '0;
            n_wsum  = '0;
            n_len   = '0;
            n_below = '0;
        end else begin
            n_col = col_cur + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flux  <= '0;
            r_wsum  <= '0;
            r_len   <= '0;
            r_below <= '0;
        end else if (pix_acc) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flux  <= n_flux;
            r_wsum  <= n_wsum;
            r_len   <= n_len;
            r_below <= n_below;
        end
    end

    // snapshot of the closing run, taken with the pixel request
    always_ff @(posedge i_clk) begin
        if (pix_acc && emit) begin
            r_rec_flux <= flux_cur;
            r_rec_len  <= len_cur;
            r_rec_row  <= row_cur;
        end
    end

    // quotient is below 2^CX_BITS, so the upper dividend bits start the remainder
    assign div_start = pix_acc && emit;

    rrcd_div #(
        .NUM_BITS (FLUX_BITS),
        .Q_BITS   (CX_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_rem_init (wsum_cur[WSUM_BITS-1:COL_BITS]),
        .i_low      ({wsum_cur[COL_BITS-1:0], {FRACTION_BITS{1'b0}}}),
        .i_divisor  (flux_cur),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // rounded centroid column, half up
    assign round_sum = {1'b0, div_quot} + HALF;

    // row store: written with every pixel, read once per record
    rrcd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_ROW_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (col_cur),
        .i_wdata (v),
        .i_re    (r_state == S_RD),
        .i_raddr (r_peak_col),
        .o_rdata (ram_rdata)
    );

    // record sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PIX;
            o_valid <= 1'b0;
        end else begin
            // a record leaving while the next one loads is replaced in S_OUT
            if (o_valid && i_ready && (r_state != S_OUT)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_PIX: begin
                    if (div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_cx       <= div_quot;
                        r_peak_col <= round_sum[FRACTION_BITS+COL_BITS-1:FRACTION_BITS];
                        // zero centroid is dropped
                        r_state    <= (div_quot == '0) ? S_PIX : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid      <= 1'b1;
                        o_centroid_x <= r_cx;
                        o_row_index  <= r_rec_row;
                        o_peak_value <= ram_rdata;
                        o_run_width  <= r_rec_len;
                        o_run_flux   <= r_rec_flux;
                        r_state      <= S_PIX;
                    end
                end
                default: begin
                    r_state <= S_PIX;
                end
            endcase
        end
    end

endmodule

// ===== tb/row_run_centroid_detect_core_test.sv =====
`default_nettype none

module row_run_centroid_detect_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rrcd_pkg::*;

    // one edge record as the block shows it
    typedef struct packed {
        logic [19:0] centroid;
        logic [11:0] row;
        logic [15:0] peak;
        logic [12:0] width;
        logic [27:0] flux;
    } edge_rec_t;

    // one directed pixel, with a typed record where the result is obvious
    typedef struct {
        logic [15:0] pix;
        bit          fs;
        bit          typed;
        edge_rec_t   rec;
    } pixel_row_t;

    // register setting for one random phase
    typedef struct {
        int unsigned thr;
        int unsigned off;
        int unsigned lim;
        int unsigned minw;
        int unsigned roww;
        int unsigned items;
        int unsigned mode;
    } phase_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_ADDR_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_pixel_value = '0;
    logic        i_frame_start = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [19:0] o_centroid_x;
    logic [11:0] o_row_index;
    logic [15:0] o_peak_value;
    logic [12:0] o_run_width;
    logic [27:0] o_run_flux;

    row_run_centroid_detect_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_centroid_x  (o_centroid_x),
        .o_row_index   (o_row_index),
        .o_peak_value  (o_peak_value),
        .o_run_width   (o_run_width),
        .o_run_flux    (o_run_flux)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // records still owed by the block, oldest first
    edge_rec_t   pending_records[$];
    int unsigned mismatches = 0;
    int unsigned records_seen = 0;
    int unsigned pixels_sent = 0;
    int unsigned idle_cycles = 0;

    // idle percentages, written only by the stimulus process
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          pressure_go = 1'b0;

    // predictor copy of the block's registers and run state
    logic [15:0] reg_thr;
    logic [15:0] reg_off;
    logic [7:0]  reg_lim;
    logic [12:0] reg_minw;
    logic [12:0] reg_roww;
    int unsigned col_cnt;
    int unsigned row_cnt;
    longint unsigned flux_acc;
    longint unsigned wsum_acc;
    int unsigned run_len;
    int unsigned below_cnt;
    logic [15:0] row_mem [0:4095];

    function automatic void clear_run();
        flux_acc = 0;
        wsum_acc = 0;
        run_len = 0;
        below_cnt = 0;
    endfunction

    // advance the run state by one pixel, returns 1 when a record comes out
    function automatic bit centroid_step(input logic [15:0] pix, input bit fs,
                                         output edge_rec_t rec);
        longint unsigned v, q, r, cx, peak_col;
        int unsigned eff_w;
        bit got;
        got = 1'b0;
        rec = '0;
        eff_w = (reg_roww == 0 || reg_roww > 4096) ? 4096 : reg_roww;
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
            clear_run();
        end
        v = (pix >= reg_off) ? pix - reg_off : 0;
        row_mem[col_cnt] = v[15:0];
        if (v >= reg_thr || (run_len != 0 && below_cnt <= reg_lim)) begin
            if (v < reg_thr) begin
                if (below_cnt < 255) below_cnt++;
            end else begin
                below_cnt = 0;
            end
            wsum_acc += longint'(col_cnt) * v;
            flux_acc += v;
            run_len++;
        end else if (run_len != 0) begin
            if (run_len >= reg_minw && flux_acc != 0) begin
                q  = wsum_acc / flux_acc;
                r  = wsum_acc % flux_acc;
                cx = (q << 8) + ((r << 8) / flux_acc);
                if (cx != 0) begin
                    peak_col = (cx + 128) >> 8;
                    rec.centroid = cx[19:0];
                    rec.row      = row_cnt[11:0];
                    rec.peak     = (peak_col < 4096) ? row_mem[peak_col] : '0;
                    rec.width    = run_len[12:0];
                    rec.flux     = flux_acc[27:0];
                    got = 1'b1;
                end
            end
            clear_run();
        end
        if (col_cnt + 1 >= eff_w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= 4096) ? 0 : row_cnt + 1;
            clear_run();
        end else begin
            col_cnt++;
        end
        return got;
    endfunction

    // record side: random ready with one long hold-off for back pressure
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (pressure_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // record checker
    always @(posedge i_clk) begin
        edge_rec_t got_rec, want;
        if (i_rst_n && o_valid && i_ready) begin
            got_rec = '{o_centroid_x, o_row_index, o_peak_value, o_run_width, o_run_flux};
            records_seen++;
            if (pending_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected record cx=%0d row=%0d peak=%0d w=%0d flux=%0d",
                             o_centroid_x, o_row_index, o_peak_value, o_run_width,
                             o_run_flux);
            end else begin
                want = pending_records.pop_front();
                if (got_rec.centroid !== want.centroid || got_rec.row !== want.row ||
                    got_rec.peak !== want.peak || got_rec.width !== want.width ||
                    got_rec.flux !== want.flux) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("record mismatch exp cx=%0d row=%0d peak=%0d w=%0d flux=%0d, got cx=%0d row=%0d peak=%0d w=%0d flux=%0d",
                                 want.centroid, want.row, want.peak, want.width, want.flux,
                                 o_centroid_x, o_row_index, o_peak_value, o_run_width,
                                 o_run_flux);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("row_run_centroid_detect_core_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // register write, only while nothing is in flight
    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_BITS-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD: reg_thr  = value[15:0];
            CFG_OFFSET:    reg_off  = value[15:0];
            CFG_BAD_LIMIT: reg_lim  = value[7:0];
            CFG_MIN_WIDTH: reg_minw = value[12:0];
            CFG_ROW_WIDTH: reg_roww = value[12:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input phase_t p);
        write_reg(CFG_THRESHOLD, p.thr);
        write_reg(CFG_OFFSET, p.off);
        write_reg(CFG_BAD_LIMIT, p.lim);
        write_reg(CFG_MIN_WIDTH, p.minw);
        write_reg(CFG_ROW_WIDTH, p.roww);
    endtask

    // offer one pixel request, then predict once it is taken
    task automatic send_pixel(input logic [15:0] pix, input bit fs, input bit typed,
                              input edge_rec_t typed_rec);
        edge_rec_t rec;
        bit got;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid       <= 1'b1;
        i_pixel_value <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
        got = centroid_step(pix, fs, rec);
        if (typed) pending_records.push_back(typed_rec);
        else if (got) pending_records.push_back(rec);
    endtask

    // raw pixel at a level relative to threshold, shifted up by the offset; one in twenty is random
    function automatic logic [15:0] make_pixel(input bit bright);
        int unsigned lvl, raw;
        if ($urandom_range(19) == 0) return 16'($urandom);
        if (bright) lvl = $urandom_range(65535 - reg_thr) + reg_thr;
        else lvl = (reg_thr == 0) ? 0 : $urandom_range(reg_thr - 1);
        raw = lvl + reg_off;
        return (raw > 65535) ? 16'hffff : raw[15:0];
    endfunction

    pixel_row_t directed[] = '{
        // row 0: run over columns 1..3, three tolerated zeros, closed at the last column
        '{16'd0,     1'b1, 1'b0, '0},
        '{16'd200,   1'b0, 1'b0, '0},
        '{16'd200,   1'b0, 1'b0, '0},
        '{16'd200,   1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b1, '{20'd512, 12'd0, 16'd200, 13'd6, 28'd600}},
        // row 1: full scale pixels at columns 0..2
        '{16'hffff,  1'b0, 1'b0, '0},
        '{16'hffff,  1'b0, 1'b0, '0},
        '{16'hffff,  1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b1, '{20'd256, 12'd1, 16'hffff, 13'd6, 28'd196605}},
        '{16'd0,     1'b0, 1'b0, '0},
        // row 2: first run has flux only at column 0, centroid zero; second run is open at row end
        '{16'd200,   1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd99,    1'b0, 1'b0, '0},
        '{16'd100,   1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0}
    };

    // register settings walked by the random part, extremes included
    phase_t phases[] = '{
        '{1000,  50,    2,   3,    16,   200, 0},
        '{65535, 0,     0,   0,    32,   100, 0},
        '{0,     65535, 1,   1,    8,    80,  0},
        '{30000, 1000,  255, 2,    24,   100, 1},
        '{500,   200,   3,   4096, 0,    60,  1},
        '{2000,  100,   1,   2,    1,    40,  1},
        '{5000,  0,     4,   5,    4096, 100, 2},
        '{800,   300,   2,   1,    20,   470, 2}
    };

    initial begin
        edge_rec_t none;
        int unsigned burst_left;
        bit fs;
        none = '0;
        reg_thr  = RST_THRESHOLD;
        reg_off  = RST_OFFSET;
        reg_lim  = RST_BAD_LIMIT;
        reg_minw = RST_MIN_WIDTH;
        reg_roww = RST_ROW_WIDTH;
        col_cnt = 0;
        row_cnt = 0;
        clear_run();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: small rows, threshold 100, default tolerance
        write_all('{100, 0, 2, 3, 8, 0, 0});
        foreach (directed[k])
            send_pixel(directed[k].pix, directed[k].fs, directed[k].typed,
                       directed[k].rec);
        i_valid <= 1'b0;

        // random part, each phase starts a new frame
        foreach (phases[p]) begin
            write_all(phases[p]);
            case (phases[p].mode)
                0: begin send_idle_pct = 35; recv_idle_pct = 67; end
                1: begin send_idle_pct = 67; recv_idle_pct = 35; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            // back pressure while the sender keeps offering pixels
            if (p == phases.size() - 1) pressure_go = 1'b1;
            burst_left = 0;
            for (int unsigned n = 0; n < phases[p].items; n++) begin
                fs = (n == 0) || ($urandom_range(99) == 0);
                if (burst_left == 0 && $urandom_range(99) < 15)
                    burst_left = $urandom_range(12, 1);
                if (burst_left > 0) begin
                    burst_left--;
                    send_pixel(make_pixel($urandom_range(99) < 80), fs, 1'b0, none);
                end else begin
                    send_pixel(make_pixel(1'b0), fs, 1'b0, none);
                end
            end
            i_valid <= 1'b0;
        end

        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_records.size() != 0) mismatches++;

        $display("sent %0d pixels over %0d register settings, checked %0d edge records",
                 pixels_sent, phases.size() + 1, records_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("row_run_centroid_detect_core_test passed");
        end else begin
            $display("row_run_centroid_detect_core_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
